@@ rtl/asp_pkg.sv @@
// Shared types for the animated image sniffer: the input and result words,
// the outcome codes and the result bundle passed from the parser to the top.
// No dependencies.
package asp_pkg;

	// Verdict codes carried in the outcome field.
	typedef enum logic [2:0] {
		OC_FRAMES      = 3'd0,
		OC_END         = 3'd1,
		OC_BAD_SIG     = 3'd2,
		OC_UNKNOWN     = 3'd3,
		OC_CANCEL      = 3'd4,
		OC_UNSUPPORTED = 3'd5
	} outcome_t;

	// One input word: a file byte and its sideband.
	typedef struct packed {
		logic [7:0] data_byte;
		logic [1:0] container;
		logic       cancel;
		logic       last_byte;
	} item_t;

	// One result word.
	typedef struct packed {
		logic       animated;
		logic [2:0] outcome;
	} verdict_t;

	// Result of parsing one byte.
	typedef struct packed {
		logic     valid;
		verdict_t word;
	} parse_res_t;

endpackage

@@ rtl/asp_parser.sv @@
// Byte-at-a-time GIF / WebP parser that holds the per-file parse state.
// Depends on asp_pkg for the word and result types.
module asp_parser
	import asp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  item_t      item,
	output parse_res_t res
);

	typedef enum logic [3:0] {
		PH_START    = 4'd0,
		PH_W_HDR    = 4'd1,
		PH_W_CHUNK  = 4'd2,
		PH_W_SKIP   = 4'd3,
		PH_G_HDR    = 4'd4,
		PH_G_GCT    = 4'd5,
		PH_G_TOP    = 4'd6,
		PH_G_EXTLBL = 4'd7,
		PH_G_SUBLEN = 4'd8,
		PH_G_SUBDAT = 4'd9,
		PH_G_DESC   = 4'd10,
		PH_G_LCT    = 4'd11,
		PH_G_LZWMIN = 4'd12
	} phase_t;

	localparam logic [1:0]  KIND_GIF     = 2'd0;
	localparam logic [1:0]  KIND_WEBP    = 2'd1;
	localparam logic [31:0] TAG_RIFF     = 32'h5249_4646;
	localparam logic [31:0] TAG_WEBP     = 32'h5745_4250;
	localparam logic [31:0] TAG_ANIM     = 32'h414E_494D;
	localparam logic [31:0] TAG_ANMF     = 32'h414E_4D46;
	localparam logic [47:0] GIF_SIG      = 48'h4749_4638_3761;
	localparam logic [7:0]  CHAR_7       = 8'h37;
	localparam logic [7:0]  CHAR_9       = 8'h39;
	localparam logic [7:0]  BYTE_TRAILER = 8'h3B;
	localparam logic [7:0]  BYTE_EXT     = 8'h21;
	localparam logic [7:0]  BYTE_IMAGE   = 8'h2C;

	// Byte idx (0 = first on the wire) of a four-character tag.
	function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] idx);
		logic [7:0] r;
		unique case (idx)
			2'd0: r = tag[31:24];
			2'd1: r = tag[23:16];
			2'd2: r = tag[15:8];
			default: r = tag[7:0];
		endcase
		return r;
	endfunction

	// Byte idx of the GIF signature; the version digit is checked apart.
	function automatic logic [7:0] gif_byte(input logic [2:0] idx);
		logic [7:0] r;
		unique case (idx)
			3'd0: r = GIF_SIG[47:40];
			3'd1: r = GIF_SIG[39:32];
			3'd2: r = GIF_SIG[31:24];
			3'd3: r = GIF_SIG[23:16];
			3'd4: r = GIF_SIG[15:8];
			3'd5: r = GIF_SIG[7:0];
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// Colour table size: three bytes per entry, 2 << n entries.
	function automatic logic [9:0] table_bytes(input logic [2:0] n);
		return 10'd6 << n;
	endfunction

	phase_t      phase_q, n_phase, eff_phase;
	logic [3:0]  fpos_q, n_fpos, p;
	logic [32:0] skip_q, n_skip, skip_dec, chunk_skip;
	logic [55:0] hdr_q, n_hdr;
	logic [3:0]  flags_q, n_flags;
	logic        first_q, n_first;
	logic        given_q;
	logic        unsup, decided, anim, skip_done;
	outcome_t    oc;
	logic [7:0]  b;
	logic [31:0] tag, size;

	assign b         = item.data_byte;
	assign skip_dec  = (skip_q != '0) ? skip_q - 33'd1 : '0;
	assign skip_done = (skip_dec == '0);
	assign tag       = hdr_q[55:24];
	assign size      = {b, hdr_q[7:0], hdr_q[15:8], hdr_q[23:16]};
	assign chunk_skip = {1'b0, size} + {32'd0, size[0]};

	// Phase on this byte: the first byte of a file picks the container.
	always_comb begin
		unsup     = 1'b0;
		eff_phase = phase_q;
		p         = fpos_q;
		if (phase_q == PH_START) begin
			p = '0;
			if (item.container == KIND_GIF) begin
				eff_phase = PH_G_HDR;
			end else if (item.container == KIND_WEBP) begin
				eff_phase = PH_W_HDR;
			end else begin
				unsup = 1'b1;
			end
		end
	end

	// Next state and decision for one byte.
	always_comb begin
		n_phase = eff_phase;
		n_fpos  = p;
		n_skip  = skip_q;
		n_hdr   = hdr_q;
		n_flags = flags_q;
		n_first = first_q;
		decided = 1'b0;
		anim    = 1'b0;
		oc      = OC_END;
		if (unsup) begin
			decided = 1'b1;
			oc      = OC_UNSUPPORTED;
		end else begin
			unique case (eff_phase)
				PH_W_HDR: begin
					if ((p < 4'd4 && b != tag_byte(TAG_RIFF, p[1:0])) ||
					    (p >= 4'd8 && p < 4'd12 && b != tag_byte(TAG_WEBP, p[1:0]))) begin
						decided = 1'b1;
						oc      = OC_BAD_SIG;
					end else if (p >= 4'd11) begin
						n_phase = PH_W_CHUNK;
						n_fpos  = '0;
						n_hdr   = '0;
					end else begin
						n_fpos = p + 4'd1;
					end
				end
				PH_W_CHUNK: begin
					n_hdr  = {hdr_q[47:0], b};
					n_fpos = p + 4'd1;
					if (p >= 4'd7) begin
						if (tag == TAG_ANIM || tag == TAG_ANMF) begin
							decided = 1'b1;
							anim    = 1'b1;
							oc      = OC_FRAMES;
						end else begin
							n_skip = chunk_skip;
							n_fpos = '0;
							n_hdr  = '0;
							if (chunk_skip != '0) begin
								n_phase = PH_W_SKIP;
							end
						end
					end
				end
				PH_W_SKIP, PH_G_GCT, PH_G_SUBDAT, PH_G_LCT: begin
					n_skip = skip_dec;
					if (skip_done) begin
						unique case (eff_phase)
							PH_W_SKIP: n_phase = PH_W_CHUNK;
							PH_G_GCT:  n_phase = PH_G_TOP;
							PH_G_SUBDAT: n_phase = PH_G_SUBLEN;
							default:   n_phase = PH_G_LZWMIN;
						endcase
					end
				end
				PH_G_HDR: begin
					if (p == 4'd4 && b != CHAR_7 && b != CHAR_9) begin
						decided = 1'b1;
						oc      = OC_BAD_SIG;
					end else if (p < 4'd6 && p != 4'd4 && b != gif_byte(p[2:0])) begin
						decided = 1'b1;
						oc      = OC_BAD_SIG;
					end else begin
						if (p == 4'd10) begin
							n_flags = {b[7], b[2:0]};
						end
						if (p >= 4'd12) begin
							n_fpos = '0;
							if (flags_q[3]) begin
								n_skip  = {23'd0, table_bytes(flags_q[2:0])};
								n_phase = PH_G_GCT;
							end else begin
								n_phase = PH_G_TOP;
							end
						end else begin
							n_fpos = p + 4'd1;
						end
					end
				end
				PH_G_TOP: begin
					if (b == BYTE_TRAILER) begin
						decided = 1'b1;
						oc      = OC_END;
					end else if (b == BYTE_EXT) begin
						n_phase = PH_G_EXTLBL;
					end else if (b == BYTE_IMAGE) begin
						if (first_q) begin
							decided = 1'b1;
							anim    = 1'b1;
							oc      = OC_FRAMES;
						end else begin
							n_first = 1'b1;
							n_phase = PH_G_DESC;
							n_fpos  = '0;
						end
					end else begin
						decided = 1'b1;
						oc      = OC_UNKNOWN;
					end
				end
				PH_G_EXTLBL, PH_G_LZWMIN: begin
					n_phase = PH_G_SUBLEN;
				end
				PH_G_SUBLEN: begin
					if (b == 8'd0) begin
						n_phase = PH_G_TOP;
					end else begin
						n_skip  = {25'd0, b};
						n_phase = PH_G_SUBDAT;
					end
				end
				PH_G_DESC: begin
					if (p >= 4'd8) begin
						n_flags = {b[7], b[2:0]};
						n_fpos  = '0;
						if (b[7]) begin
							n_skip  = {23'd0, table_bytes(b[2:0])};
							n_phase = PH_G_LCT;
						end else begin
							n_phase = PH_G_LZWMIN;
						end
					end else begin
						n_fpos = p + 4'd1;
					end
				end
				default: begin
					decided = 1'b1;
					oc      = OC_END;
				end
			endcase
		end
	end

	// One verdict per file: cancel first, then the parse, then end of file.
	always_comb begin
		res.valid         = step && !given_q && (item.cancel || decided || item.last_byte);
		res.word.animated = 1'b0;
		res.word.outcome  = OC_END;
		if (item.cancel) begin
			res.word.outcome = OC_CANCEL;
		end else if (decided) begin
			res.word.animated = anim;
			res.word.outcome  = oc;
		end
	end

	// Parse state; the last byte of a file returns everything to the start.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			fpos_q  <= '0;
			skip_q  <= '0;
			hdr_q   <= '0;
			flags_q <= '0;
			first_q <= 1'b0;
			given_q <= 1'b0;
		end else if (step) begin
			if (item.last_byte) begin
				phase_q <= PH_START;
				fpos_q  <= '0;
				skip_q  <= '0;
				hdr_q   <= '0;
				flags_q <= '0;
				first_q <= 1'b0;
				given_q <= 1'b0;
			end else if (!given_q) begin
				if (item.cancel) begin
					given_q <= 1'b1;
				end else begin
					phase_q <= n_phase;
					fpos_q  <= n_fpos;
					skip_q  <= n_skip;
					hdr_q   <= n_hdr;
					flags_q <= n_flags;
					first_q <= n_first;
					given_q <= decided;
				end
			end
		end
	end

`ifndef SYNTHESIS
	// The last byte of a file leaves the parser ready for a new file.
	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.last_byte |=> phase_q == PH_START && !given_q && !first_q)
		else $error("parser not at start after last byte");

	// A skip phase always has bytes left to skip.
	a_skip_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_W_SKIP || phase_q == PH_G_GCT || phase_q == PH_G_SUBDAT ||
		 phase_q == PH_G_LCT) |-> skip_q != '0)
		else $error("skip phase entered with empty count");

	// Once a verdict is given, no further verdict for the same file.
	a_one_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !item.last_byte |=> !res.valid)
		else $error("second verdict for one file");
`endif

endmodule

@@ rtl/animated_image_sniffer.sv @@
// Top level of the animated image sniffer: input register, parser and
// result register with the valid/stall handshakes. Depends on asp_pkg and
// asp_parser.
//
// Usage: a file is sent one byte per word on the item channel, in order,
// tagged with its container kind (GIF, WebP or other), a cancel bit and a
// last_byte bit that closes the file. Each file yields exactly one word on
// the verdict channel: animated plus an outcome code. The verdict comes at
// the byte that settles it (second frame, ANIM/ANMF chunk, trailer, bad
// signature, unknown block, cancel, unsupported kind) or at last_byte.
// Bytes after the verdict are consumed without result until last_byte.
// Throughput: one byte per cycle unless the verdict stalls; every byte is
// handled in a single pass of the parser between the input register and the
// result register. A verdict is registered in the result register once its
// byte has passed from the input register through the parser.
// Stall: while the result register holds a word that is stalled, the input
// register holds too and item_stall rises once it is full; no word is lost.
// Reset: arst_n clears both registers' valid bits and all parse state, so
// the next byte starts a new file.
module animated_image_sniffer
	import asp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_stall,
	input  item_t    item,
	output logic     verdict_valid,
	input  logic     verdict_stall,
	output verdict_t verdict
);

	logic       valid_s1;
	item_t      item_s1;
	logic       advance, fire;
	parse_res_t res;
	logic       verdict_valid_q;
	verdict_t   verdict_q;

	// The input register moves on whenever the result register can take a word.
	assign advance    = !verdict_valid_q || !verdict_stall;
	assign fire       = valid_s1 && advance;
	assign item_stall = valid_s1 && !advance;

	asp_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (fire),
		.item   (item_s1),
		.res    (res)
	);

	// Control bits of the input and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1        <= 1'b0;
			verdict_valid_q <= 1'b0;
		end else begin
			if (!item_stall) begin
				valid_s1 <= item_valid;
			end
			if (advance) begin
				verdict_valid_q <= fire && res.valid;
			end
		end
	end

	// Payload of the input and result registers.
	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
		if (fire && res.valid) begin
			verdict_q <= res.word;
		end
	end

	assign verdict_valid = verdict_valid_q;
	assign verdict       = verdict_q;

`ifndef SYNTHESIS
	// Only the frames outcome may report an animated image.
	a_anim_frames: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid && verdict.animated |-> verdict.outcome == OC_FRAMES)
		else $error("animated set with an outcome other than frames");
`endif

endmodule
